### rtl/obtf_pkg.sv
// Shared types and codes for the overwriting byte trace FIFO.
package obtf_pkg;

	// Input word mode codes.
	localparam logic MODE_PUSH = 1'b0;
	localparam logic MODE_POP  = 1'b1;

	// Memory strobes from the pointer control to the ring memory.
	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} mem_ctl_t;

	// Pop request from the pointer control to the output stage.
	typedef struct packed {
		logic issue;
		logic hit;
	} pop_req_t;

endpackage

### rtl/overwriting_byte_trace_fifo_top.sv
// Top level of the overwriting byte trace FIFO.
// A pop word's result passes through the read stage and then the output register.
// Throughput: one word per cycle while in_ready is high; a push uses the ring memory
// write port and a pop its read port. A stalled output holds the read stage and the input in turn.
// Reset clears the pointers, the fill count and the valid flags; the ring
// memory is not cleared, since only written entries are ever read.
module overwriting_byte_trace_fifo_top #(
	parameter int FIFO_DEPTH = 512
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       mode,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] read_byte,
	output logic       byte_valid
);
	import obtf_pkg::*;

	localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

	mem_ctl_t      mem_ctl;
	pop_req_t      pop_req;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_data;
	logic          stage_free;
	logic          accept;

	// Accept a word whenever the read stage can move on.
	assign in_ready = stage_free;
	assign accept   = in_valid && in_ready;

	obtf_ptr_ctrl #(
		.FIFO_DEPTH(FIFO_DEPTH)
	) u_ptr_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.mode    (mode),
		.mem_ctl (mem_ctl),
		.wr_addr (wr_addr),
		.rd_addr (rd_addr),
		.pop_req (pop_req)
	);

	obtf_ring_mem #(
		.FIFO_DEPTH(FIFO_DEPTH)
	) u_ring_mem (
		.clk     (clk),
		.mem_ctl (mem_ctl),
		.wr_addr (wr_addr),
		.wr_data (data_byte),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	obtf_out_stage u_out_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_req    (pop_req),
		.rd_data    (rd_data),
		.out_ready  (out_ready),
		.stage_free (stage_free),
		.out_valid  (out_valid),
		.read_byte  (read_byte),
		.byte_valid (byte_valid)
	);

endmodule

### rtl/obtf_ring_mem.sv
// Ring memory of trace bytes: one write port, one read port, registered read data.
module obtf_ring_mem #(
	parameter int FIFO_DEPTH = 512,
	localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1
) (
	input  logic                clk,
	input  obtf_pkg::mem_ctl_t  mem_ctl,
	input  logic [AW-1:0]       wr_addr,
	input  logic [7:0]          wr_data,
	input  logic [AW-1:0]       rd_addr,
	output logic [7:0]          rd_data
);
	import obtf_pkg::*;

	logic [7:0] mem_q [FIFO_DEPTH];
	logic [7:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (mem_ctl.wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (mem_ctl.rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### rtl/obtf_ptr_ctrl.sv
// Write and read pointers and fill count of the ring, with memory strobes.
module obtf_ptr_ctrl #(
	parameter int FIFO_DEPTH = 512,
	localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1,
	localparam int CW = $clog2(FIFO_DEPTH + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic                mode,
	output obtf_pkg::mem_ctl_t  mem_ctl,
	output logic [AW-1:0]       wr_addr,
	output logic [AW-1:0]       rd_addr,
	output obtf_pkg::pop_req_t  pop_req
);
	import obtf_pkg::*;

	localparam logic [AW-1:0] LAST_IDX = AW'(FIFO_DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(FIFO_DEPTH);

	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] fill_q;
	logic          push;
	logic          pop;
	logic          full;
	logic          empty;
	logic [AW-1:0] wr_next;
	logic [AW-1:0] rd_next;

	assign push  = accept && (mode == MODE_PUSH);
	assign pop   = accept && (mode == MODE_POP);
	assign full  = (fill_q == FULL_CNT);
	assign empty = (fill_q == '0);

	// Wrapping increments of both pointers.
	assign wr_next = (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + AW'(1);
	assign rd_next = (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + AW'(1);

	// A push on a full ring drops the oldest byte by moving the read pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else if (push) begin
			wr_ptr_q <= wr_next;
			if (full) begin
				rd_ptr_q <= rd_next;
			end else begin
				fill_q <= fill_q + CW'(1);
			end
		end else if (pop && !empty) begin
			rd_ptr_q <= rd_next;
			fill_q   <= fill_q - CW'(1);
		end
	end

	assign wr_addr       = wr_ptr_q;
	assign rd_addr       = rd_ptr_q;
	assign mem_ctl.wr_en = push;
	assign mem_ctl.rd_en = pop && !empty;
	assign pop_req.issue = pop;
	assign pop_req.hit   = !empty;

endmodule

### rtl/obtf_out_stage.sv
// Pop result staging: memory read stage, then the output register.
module obtf_out_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  obtf_pkg::pop_req_t  pop_req,
	input  logic [7:0]          rd_data,
	input  logic                out_ready,
	output logic                stage_free,
	output logic                out_valid,
	output logic [7:0]          read_byte,
	output logic                byte_valid
);
	import obtf_pkg::*;

	logic       valid_s1;
	logic       hit_s1;
	logic       out_valid_q;
	logic       out_hit_q;
	logic [7:0] out_byte_q;
	logic       out_free;
	logic       move;

	assign out_free   = !out_valid_q || out_ready;
	assign move       = valid_s1 && out_free;
	assign stage_free = !valid_s1 || out_free;

	// Read stage: holds a pop while the ring memory registers its data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stage_free) begin
			valid_s1 <= pop_req.issue;
		end
	end

	always_ff @(posedge clk) begin
		if (stage_free && pop_req.issue) begin
			hit_s1 <= pop_req.hit;
		end
	end

	// Output register; an empty-ring pop gives zero padding.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			out_hit_q  <= hit_s1;
			out_byte_q <= hit_s1 ? rd_data : 8'h00;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_byte  = out_byte_q;
	assign byte_valid = out_hit_q;

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the overwriting byte trace FIFO top level.
module tb;
	import obtf_pkg::*;

	localparam int TRACE_DEPTH = 512;
	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 10;

	// One answered pop word: the byte and whether it was real or padding.
	typedef struct packed {
		logic [7:0] value;
		logic       real_flag;
	} pop_answer_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic       mode = MODE_PUSH;
	logic [7:0] data_byte = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] read_byte;
	logic       byte_valid;

	// Own copy of the ring state, advanced once per accepted word.
	logic [7:0] trace_ring [TRACE_DEPTH];
	logic [8:0] ring_wr_ptr;
	logic [8:0] ring_rd_ptr;
	logic [9:0] ring_fill;

	pop_answer_t pop_answers [$];
	int          error_count = 0;
	int          quiet_cycles = 0;
	int          send_idle_pct = 0;
	int          sink_stall_pct = 0;

	overwriting_byte_trace_fifo_top #(
		.FIFO_DEPTH(TRACE_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.data_byte(data_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.read_byte(read_byte),
		.byte_valid(byte_valid)
	);

	always #2 clk = ~clk;

	// Print one mismatch line and count it.
	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t: %s: got %0h, expected %0h", $realtime, what, got, want);
		error_count++;
	endtask

	// Advance the ring copy for one accepted word; a pop queues its answer.
	task automatic predict_trace_word(input logic m, input logic [7:0] d);
		pop_answer_t answer;
		if (m == MODE_PUSH) begin
			trace_ring[ring_wr_ptr] = d;
			ring_wr_ptr = ring_wr_ptr + 9'd1;
			// A push into a full ring drops the oldest byte.
			if (ring_fill < TRACE_DEPTH)
				ring_fill = ring_fill + 10'd1;
			else
				ring_rd_ptr = ring_rd_ptr + 9'd1;
		end else begin
			if (ring_fill != 0) begin
				answer.value = trace_ring[ring_rd_ptr];
				answer.real_flag = 1'b1;
				ring_rd_ptr = ring_rd_ptr + 9'd1;
				ring_fill = ring_fill - 10'd1;
			end else begin
				answer.value = 8'h00;
				answer.real_flag = 1'b0;
			end
			pop_answers.push_back(answer);
		end
	endtask

	// Offer one word, idling first at the current rate, and return once it is taken.
	// Valid stays high on return so back-to-back words need no extra edge.
	task automatic send_word(input logic m, input logic [7:0] d);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		data_byte <= d;
		do
			@(posedge clk);
		while (!in_ready);
		predict_trace_word(m, d);
	endtask

	// Hold the sender off until every expected answer has come back.
	task automatic wait_answers_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pop_answers.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_idling(input int send_pct, input int stall_pct);
		send_idle_pct = send_pct;
		sink_stall_pct = stall_pct;
	endtask

	// Pops on an empty ring must answer zero padding marked not valid.
	task automatic test_read_when_empty();
		send_word(MODE_POP, 8'hFF);
		send_word(MODE_POP, 8'h00);
	endtask

	// Extreme and alternating byte values, interleaved pushes and pops.
	task automatic test_byte_extremes();
		send_word(MODE_PUSH, 8'h00);
		send_word(MODE_PUSH, 8'hFF);
		send_word(MODE_POP, 8'h5A);
		send_word(MODE_PUSH, 8'h01);
		send_word(MODE_PUSH, 8'h80);
		send_word(MODE_PUSH, 8'h55);
		send_word(MODE_PUSH, 8'hAA);
		send_word(MODE_POP, 8'h00);
		send_word(MODE_POP, 8'hFF);
		send_word(MODE_POP, 8'h00);
		send_word(MODE_POP, 8'h00);
		send_word(MODE_POP, 8'h00);
		send_word(MODE_POP, 8'hFF);
	endtask

	// Push past the depth so the oldest bytes are overwritten, then drain fully.
	task automatic test_overwrite_when_full();
		for (int i = 0; i < TRACE_DEPTH + 6; i++)
			send_word(MODE_PUSH, 8'($urandom));
		for (int i = 0; i < TRACE_DEPTH + 2; i++)
			send_word(MODE_POP, 8'($urandom));
	endtask

	// Bursts of mixed words, each burst leaning toward pushes, pops or neither.
	task automatic test_random_traffic(input int word_total);
		int sent;
		int burst_len;
		int pop_pct;
		sent = 0;
		while (sent < word_total) begin
			burst_len = $urandom_range(24, 1);
			case ($urandom_range(2))
				0: pop_pct = 15;
				1: pop_pct = 50;
				default: pop_pct = 85;
			endcase
			for (int i = 0; i < burst_len; i++) begin
				send_word(($urandom_range(99) < pop_pct) ? MODE_POP : MODE_PUSH,
					8'($urandom));
				sent++;
			end
		end
	endtask

	// Take each answer as it is handed over and compare it with the oldest one due.
	always @(posedge clk) begin
		pop_answer_t due;
		if (arst_n && out_valid && out_ready) begin
			if (pop_answers.size() == 0) begin
				report_mismatch("answer with none due", read_byte, 0);
			end else begin
				due = pop_answers.pop_front();
				if (read_byte !== due.value)
					report_mismatch("read_byte", read_byte, due.value);
				if (byte_valid !== due.real_flag)
					report_mismatch("byte_valid", byte_valid, due.real_flag);
			end
		end
		out_ready <= ($urandom_range(99) >= sink_stall_pct);
	end

	// End the run if no word moves on either side for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		ring_wr_ptr = '0;
		ring_rd_ptr = '0;
		ring_fill = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_idling(0, 0);
		test_read_when_empty();
		test_byte_extremes();
		wait_answers_drained();

		set_idling(26, 26);
		test_overwrite_when_full();
		wait_answers_drained();

		set_idling(0, 0);
		test_random_traffic(130);
		set_idling(75, 0);
		test_random_traffic(130);
		set_idling(0, 75);
		test_random_traffic(130);
		set_idling(26, 26);
		test_random_traffic(130);

		wait_answers_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && pop_answers.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
